/* rtl/core/srm_pkg.sv */
package srm_pkg;

    localparam int NUM_REGS   = 6;
    localparam int REG_W      = 64;
    localparam int HALF_W     = REG_W / 2;
    localparam int IDX_W      = 3;
    localparam int OPND_W     = 32;
    localparam int OP_W       = 4;
    localparam int IP_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [IP_W-1:0] IP_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_IP_SLOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = 2'd1;

    localparam logic [IDX_W-1:0] IP_SLOT_RST  = 3'd2;
    localparam logic [IP_W-1:0]  PROG_LEN_RST = 16'd32;

    typedef enum logic [OP_W-1:0] {
        OP_MULI = 4'd0,
        OP_SETI = 4'd1,
        OP_BANI = 4'd2,
        OP_GTRI = 4'd3,
        OP_GTRR = 4'd4,
        OP_EQRR = 4'd5,
        OP_ADDI = 4'd6,
        OP_GTIR = 4'd7,
        OP_EQIR = 4'd8,
        OP_MULR = 4'd9,
        OP_ADDR = 4'd10,
        OP_BORR = 4'd11,
        OP_BORI = 4'd12,
        OP_EQRI = 4'd13,
        OP_BANR = 4'd14,
        OP_SETR = 4'd15
    } op_t;

    // Multiply still waiting in the result stage to write its destination.
    typedef struct packed {
        logic             pend;
        logic             ipw;
        logic [IDX_W-1:0] dest;
    } hz_t;

    typedef struct packed {
        logic              stall;
        logic              is_mul;
        logic              bad;
        logic              ipw;
        logic [REG_W-1:0]  val;
        logic [REG_W-1:0]  p0;
        logic [HALF_W-1:0] p1;
        logic [HALF_W-1:0] p2;
        logic [IP_W-1:0]   next_ip;
    } exec_t;

    function automatic logic [IP_W-1:0] sat_next(input logic [REG_W-1:0] base);
        logic [IP_W-1:0] res;
        if (base >= REG_W'(IP_MAX) - REG_W'(1))
        begin
            res = IP_MAX;
        end
        else
        begin
            res = base[IP_W-1:0] + IP_W'(1);
        end
        return res;
    endfunction

endpackage

/* rtl/core/srm_if.sv */
interface srm_req_if;
    logic                             valid;
    logic                             ready;
    logic [srm_pkg::OP_W-1:0]         req_type;
    logic [srm_pkg::OPND_W-1:0]       operand_a;
    logic [srm_pkg::OPND_W-1:0]       operand_b;
    logic [srm_pkg::IDX_W-1:0]        dest_index;

    modport source (output valid, req_type, operand_a, operand_b, dest_index, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, dest_index, output ready);
endinterface

interface srm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [srm_pkg::IP_W-1:0]         next_ip;
    logic [srm_pkg::REG_W-1:0]        write_value;
    logic                             halted;
    logic                             bad_index;

    modport source (output valid, next_ip, write_value, halted, bad_index, input ready);
    modport sink   (input valid, next_ip, write_value, halted, bad_index, output ready);
endinterface

interface srm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [srm_pkg::CFG_IDX_W-1:0]    index;
    logic [srm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/srm_exec.sv */
module srm_exec (
    input  srm_pkg::op_t                 op,
    input  logic [srm_pkg::OPND_W-1:0]   opnd_a,
    input  logic [srm_pkg::OPND_W-1:0]   opnd_b,
    input  logic [srm_pkg::IDX_W-1:0]    dest,
    input  logic [srm_pkg::REG_W-1:0]    regs [srm_pkg::NUM_REGS],
    input  logic [srm_pkg::IP_W-1:0]     ip,
    input  logic [srm_pkg::IDX_W-1:0]    ip_slot,
    input  srm_pkg::hz_t                 hz,
    output srm_pkg::exec_t               ex
);

    logic                         bound;
    logic                         a_reg;
    logic                         b_reg;
    logic                         b_used;
    logic                         a_oor;
    logic                         b_oor;
    logic                         bad;
    logic                         is_mul;
    logic                         ipw;
    logic [srm_pkg::REG_W-1:0]    a_rd;
    logic [srm_pkg::REG_W-1:0]    b_rd;
    logic [srm_pkg::REG_W-1:0]    a;
    logic [srm_pkg::REG_W-1:0]    b;
    logic [srm_pkg::REG_W-1:0]    raw;
    logic [srm_pkg::REG_W-1:0]    val;
    logic [srm_pkg::REG_W-1:0]    base;
    logic [srm_pkg::REG_W-1:0]    prod_ll;
    logic [srm_pkg::HALF_W-1:0]   prod_lh;
    logic [srm_pkg::HALF_W-1:0]   prod_hl;

    always_comb
    begin
        case (op)
            srm_pkg::OP_GTIR, srm_pkg::OP_EQIR:
            begin
                a_reg  = 1'b0;
                b_reg  = 1'b1;
                b_used = 1'b1;
            end
            srm_pkg::OP_SETI:
            begin
                a_reg  = 1'b0;
                b_reg  = 1'b0;
                b_used = 1'b0;
            end
            srm_pkg::OP_SETR:
            begin
                a_reg  = 1'b1;
                b_reg  = 1'b0;
                b_used = 1'b0;
            end
            srm_pkg::OP_ADDI, srm_pkg::OP_MULI, srm_pkg::OP_BANI,
            srm_pkg::OP_BORI, srm_pkg::OP_GTRI, srm_pkg::OP_EQRI:
            begin
                a_reg  = 1'b1;
                b_reg  = 1'b0;
                b_used = 1'b1;
            end
            default:
            begin
                a_reg  = 1'b1;
                b_reg  = 1'b1;
                b_used = 1'b1;
            end
        endcase
    end

    // The bound register reads as the current pointer, since the copy happens first.
    always_comb
    begin
        bound = ip_slot < srm_pkg::IDX_W'(srm_pkg::NUM_REGS);
        a_rd  = '0;
        b_rd  = '0;
        for (int i = 0; i < srm_pkg::NUM_REGS; i++)
        begin
            if (opnd_a == srm_pkg::OPND_W'(i))
            begin
                a_rd = (bound && ip_slot == srm_pkg::IDX_W'(i)) ?
                       srm_pkg::REG_W'(ip) : regs[i];
            end
            if (opnd_b == srm_pkg::OPND_W'(i))
            begin
                b_rd = (bound && ip_slot == srm_pkg::IDX_W'(i)) ?
                       srm_pkg::REG_W'(ip) : regs[i];
            end
        end
    end

    always_comb
    begin
        a_oor = opnd_a >= srm_pkg::OPND_W'(srm_pkg::NUM_REGS);
        b_oor = opnd_b >= srm_pkg::OPND_W'(srm_pkg::NUM_REGS);
        a     = a_reg ? a_rd : srm_pkg::REG_W'(opnd_a);
        if (!b_used)
        begin
            b = '0;
        end
        else
        begin
            b = b_reg ? b_rd : srm_pkg::REG_W'(opnd_b);
        end
        bad = (a_reg && a_oor) || (b_used && b_reg && b_oor) ||
              (dest >= srm_pkg::IDX_W'(srm_pkg::NUM_REGS));
    end

    always_comb
    begin
        case (op)
            srm_pkg::OP_ADDR, srm_pkg::OP_ADDI: raw = a + b;
            srm_pkg::OP_BANR, srm_pkg::OP_BANI: raw = a & b;
            srm_pkg::OP_BORR, srm_pkg::OP_BORI: raw = a | b;
            srm_pkg::OP_SETR, srm_pkg::OP_SETI: raw = a;
            srm_pkg::OP_GTIR, srm_pkg::OP_GTRI, srm_pkg::OP_GTRR:
                raw = srm_pkg::REG_W'(a > b);
            srm_pkg::OP_EQIR, srm_pkg::OP_EQRI, srm_pkg::OP_EQRR:
                raw = srm_pkg::REG_W'(a == b);
            default: raw = '0;
        endcase
    end

    // A 64-bit product keeps only its low half, so three 32-bit partial
    // products suffice; they are summed in the result stage.
    always_comb
    begin
        prod_ll = a[srm_pkg::HALF_W-1:0] * b[srm_pkg::HALF_W-1:0];
        prod_lh = a[srm_pkg::HALF_W-1:0] * b[srm_pkg::REG_W-1:srm_pkg::HALF_W];
        prod_hl = a[srm_pkg::REG_W-1:srm_pkg::HALF_W] * b[srm_pkg::HALF_W-1:0];
    end

    always_comb
    begin
        is_mul = (op == srm_pkg::OP_MULR) || (op == srm_pkg::OP_MULI);
        val    = bad ? '0 : raw;
        ipw    = bound && !bad && (dest == ip_slot);
        base   = (ipw && !is_mul) ? val : srm_pkg::REG_W'(ip);

        ex.stall   = hz.pend && (hz.ipw ||
                     (a_reg && opnd_a == srm_pkg::OPND_W'(hz.dest)) ||
                     (b_used && b_reg && opnd_b == srm_pkg::OPND_W'(hz.dest)));
        ex.is_mul  = is_mul;
        ex.bad     = bad;
        ex.ipw     = ipw && is_mul;
        ex.val     = val;
        ex.p0      = prod_ll;
        ex.p1      = prod_lh;
        ex.p2      = prod_hl;
        ex.next_ip = srm_pkg::sat_next(base);
    end

endmodule

/* rtl/core/six_register_machine_execute_core.sv */
// Executes one instruction per request on six 64-bit registers with the
// instruction pointer bound to a configurable register, and returns one
// response per request. A new request is taken every cycle unless execute
// stalls or the response is held. A multiply forms its three 32-bit partial
// products in the execute stage and sums them in the response stage, where
// it also writes its destination; a request that reads that destination, or
// any request after a multiply that writes the bound pointer register, waits
// for that write. Configuration writes are always ready and take effect at
// once; they belong to times when no request is in flight.
module six_register_machine_execute_core (
    input  logic             clk,
    input  logic             rst_n,
    srm_req_if.sink          req,
    srm_rsp_if.source        rsp,
    srm_cfg_if.sink          cfg
);

    logic [srm_pkg::IDX_W-1:0]    ip_slot_reg;
    logic [srm_pkg::IP_W-1:0]     prog_len_reg;

    logic                         s1_valid_reg;
    srm_pkg::op_t                 s1_type_reg;
    logic [srm_pkg::OPND_W-1:0]   s1_a_reg;
    logic [srm_pkg::OPND_W-1:0]   s1_b_reg;
    logic [srm_pkg::IDX_W-1:0]    s1_dest_reg;

    logic [srm_pkg::REG_W-1:0]    rf_reg  [srm_pkg::NUM_REGS];
    logic [srm_pkg::REG_W-1:0]    rf_next [srm_pkg::NUM_REGS];
    logic [srm_pkg::IP_W-1:0]     ip_reg;
    logic [srm_pkg::IP_W-1:0]     ip_next;

    logic                         s2_valid_reg;
    logic                         s2_valid_next;
    logic                         s2_pend_reg;
    logic                         s2_pend_next;
    logic                         s2_mul_reg;
    logic                         s2_bad_reg;
    logic                         s2_ipw_reg;
    logic [srm_pkg::IDX_W-1:0]    s2_dest_reg;
    logic [srm_pkg::REG_W-1:0]    s2_val_reg;
    logic [srm_pkg::REG_W-1:0]    s2_p0_reg;
    logic [srm_pkg::HALF_W-1:0]   s2_p1_reg;
    logic [srm_pkg::HALF_W-1:0]   s2_p2_reg;
    logic [srm_pkg::IP_W-1:0]     s2_next_ip_reg;

    srm_pkg::hz_t                 hz;
    srm_pkg::exec_t               ex;
    logic                         bound;
    logic                         s1_fire;
    logic                         req_fire;
    logic [srm_pkg::REG_W-1:0]    mul_val;
    logic [srm_pkg::IP_W-1:0]     out_ip;

    assign hz.pend = s2_pend_reg;
    assign hz.ipw  = s2_ipw_reg;
    assign hz.dest = s2_dest_reg;

    srm_exec u_exec (
        .op      (s1_type_reg),
        .opnd_a  (s1_a_reg),
        .opnd_b  (s1_b_reg),
        .dest    (s1_dest_reg),
        .regs    (rf_reg),
        .ip      (ip_reg),
        .ip_slot (ip_slot_reg),
        .hz      (hz),
        .ex      (ex)
    );

    assign bound     = ip_slot_reg < srm_pkg::IDX_W'(srm_pkg::NUM_REGS);
    assign s1_fire   = s1_valid_reg && !ex.stall && (!s2_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign mul_val = s2_p0_reg + {s2_p1_reg + s2_p2_reg, srm_pkg::HALF_W'(0)};
    assign out_ip  = s2_ipw_reg ? srm_pkg::sat_next(mul_val) : s2_next_ip_reg;

    assign rsp.valid       = s2_valid_reg;
    assign rsp.next_ip     = out_ip;
    assign rsp.write_value = s2_mul_reg ? (s2_bad_reg ? '0 : mul_val) : s2_val_reg;
    assign rsp.halted      = out_ip >= prog_len_reg;
    assign rsp.bad_index   = s2_bad_reg;

    // A pending multiply retires first; the younger request then writes over it.
    always_comb
    begin
        rf_next = rf_reg;
        ip_next = ip_reg;
        if (s2_pend_reg)
        begin
            rf_next[s2_dest_reg] = mul_val;
            if (s2_ipw_reg)
            begin
                ip_next = srm_pkg::sat_next(mul_val);
            end
        end
        if (s1_fire)
        begin
            if (bound)
            begin
                rf_next[ip_slot_reg] = srm_pkg::REG_W'(ip_reg);
            end
            if (!ex.bad && !ex.is_mul)
            begin
                rf_next[s1_dest_reg] = ex.val;
            end
            if (!ex.ipw)
            begin
                ip_next = ex.next_ip;
            end
        end
    end

    always_comb
    begin
        s2_valid_next = s1_fire || (s2_valid_reg && !rsp.ready);
        s2_pend_next  = s1_fire && ex.is_mul && !ex.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_slot_reg  <= srm_pkg::IP_SLOT_RST;
            prog_len_reg <= srm_pkg::PROG_LEN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                srm_pkg::CFG_IP_SLOT:  ip_slot_reg  <= cfg.data[srm_pkg::IDX_W-1:0];
                srm_pkg::CFG_PROG_LEN: prog_len_reg <= cfg.data[srm_pkg::IP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_pend_reg  <= 1'b0;
            ip_reg       <= '0;
            rf_reg       <= '{default: '0};
        end
        else
        begin
            s1_valid_reg <= req_fire || (s1_valid_reg && !s1_fire);
            s2_valid_reg <= s2_valid_next;
            s2_pend_reg  <= s2_pend_next;
            ip_reg       <= ip_next;
            rf_reg       <= rf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_type_reg <= srm_pkg::op_t'(req.req_type);
            s1_a_reg    <= req.operand_a;
            s1_b_reg    <= req.operand_b;
            s1_dest_reg <= req.dest_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ipw_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            s2_ipw_reg <= ex.ipw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_mul_reg     <= ex.is_mul;
            s2_bad_reg     <= ex.bad;
            s2_dest_reg    <= s1_dest_reg;
            s2_val_reg     <= ex.val;
            s2_p0_reg      <= ex.p0;
            s2_p1_reg      <= ex.p1;
            s2_p2_reg      <= ex.p2;
            s2_next_ip_reg <= ex.next_ip;
        end
    end

    a_pend_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        s2_pend_reg |-> s2_valid_reg)
        else $error("multiply write pending without a response held");

    a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s2_pend_reg |=> (!s2_pend_reg || $past(s1_fire)))
        else $error("multiply write stayed pending for more than one cycle");

    a_no_ip_race: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_pend_reg && s2_ipw_reg) |-> !s1_fire)
        else $error("request executed while the pointer update was pending");

    a_ipw_is_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_ipw_reg) |-> (s2_mul_reg && !s2_bad_reg))
        else $error("deferred pointer update on a request that is no good multiply");

endmodule
